// ===== design/fsp_pkg.sv =====
// Shared constants, codes and types for the flywheel speed regulator.
package fsp_pkg;

  localparam int CMD_LIMIT  = 127;
  localparam int FRAC_BITS  = 12;

  localparam int GAIN_W     = 16;
  localparam int ZONE_W     = 10;
  localparam int SPEED_W    = 10;
  localparam int MEAS_W     = 11;
  localparam int MODE_W     = 3;
  localparam int DRV_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  localparam int ERR_W      = MEAS_W + 1;
  localparam int DERR_W     = ERR_W + 1;
  localparam int INTEG_W    = 20;

  localparam int ACC_LIM    = CMD_LIMIT << FRAC_BITS;
  localparam int ACC_W      = $clog2(ACC_LIM + 1) + 1;

  localparam int PROD_P_W   = ERR_W + GAIN_W + 1;
  localparam int PROD_I_W   = INTEG_W + GAIN_W + 1;
  localparam int PROD_D_W   = DERR_W + GAIN_W + 1;
  localparam int ADJ_W      = PROD_I_W + 2;
  localparam int SUM_W      = ADJ_W + 1;

  // Request kinds
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_MODE = 1'b1;

  // Operating modes
  localparam logic [MODE_W-1:0] MODE_STOP             = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SLOW             = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NORMAL           = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AUTON            = 3'd3;
  localparam logic [MODE_W-1:0] MODE_AUTON_SLOW       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_AUTON_FIRST      = 3'd5;
  localparam logic [MODE_W-1:0] MODE_AUTON_SLOW_FIRST = 3'd6;
  localparam logic [MODE_W-1:0] MODE_REQ_IGNORED      = 3'd7;

  // Fixed target speeds and offsets, rpm
  localparam logic [SPEED_W:0] TGT_SLOW       = 11'd154;
  localparam logic [SPEED_W:0] TGT_AUTON_SLOW = 11'd153;
  localparam logic [SPEED_W:0] TGT_FIRST_ADD  = 11'd3;
  localparam logic [SPEED_W:0] TGT_SLOW_ADD   = 11'd8;
  localparam logic [SPEED_W:0] TGT_MAX        = 11'd1023;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_ZONE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_SPEED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTON_SPEED  = 3'd5;

  // Register reset values
  localparam logic [GAIN_W-1:0]  GAIN_P_RST = 16'd205;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST = 16'd0;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST = 16'd3277;
  localparam logic [ZONE_W-1:0]  ZONE_RST   = 10'd15;
  localparam logic [SPEED_W-1:0] SPEED_RST  = 10'd0;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [ZONE_W-1:0]  integral_zone;
    logic [SPEED_W-1:0] normal_speed;
    logic [SPEED_W-1:0] auton_speed;
  } cfg_t;

  // Error stage to accumulate stage
  typedef struct packed {
    logic                      is_tick;
    logic signed [ERR_W-1:0]   err;
    logic signed [DERR_W-1:0]  derr;
    logic signed [INTEG_W-1:0] integ;
    logic [SPEED_W-1:0]        target;
    logic [MODE_W-1:0]         mode;
  } s1_t;

endpackage

// ===== design/fsp_if.sv =====
// Request and result channel interfaces.
interface fsp_in_if import fsp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [MEAS_W-1:0] measured_speed;
  logic [MODE_W-1:0]        mode_request;

  modport source (output valid, req_type, measured_speed, mode_request, input ready);
  modport sink   (input valid, req_type, measured_speed, mode_request, output ready);
endinterface

interface fsp_out_if import fsp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DRV_W-1:0] drive_command;
  logic [SPEED_W-1:0]      target_speed;
  logic [MODE_W-1:0]       active_mode;

  modport source (output valid, drive_command, target_speed, active_mode, input ready);
  modport sink   (input valid, drive_command, target_speed, active_mode, output ready);
endinterface

// ===== design/flywheel_speed_pid_unit.sv =====
// Flywheel speed regulator top level: zoned-integral incremental PID.
//
//   channel   dir   payload                                         handshake
//   req_i     in    req_type, measured_speed, mode_request          valid/ready
//   rsp_o     out   drive_command, target_speed, active_mode        valid/ready
//   cfg       in    cfg_we_i, cfg_idx_i, cfg_wdata_i                write enable
//
// Two register stages: error/integral stage, then product/accumulate stage with
// the result register. One request per cycle unless the result channel stalls.
// Each stage holds while the one after it is full and stalled; an empty first stage
// still takes a request while a finished result waits.
// Reset (rst_ni low, async) clears mode, target and PID state and loads the
// register defaults.
module flywheel_speed_pid_unit import fsp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fsp_in_if.sink                req_i,
  fsp_out_if.source             rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t cfg;
  logic s1_valid;
  logic s1_ready;
  s1_t  s1;

  fsp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  fsp_err u_err (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (req_i.valid),
    .in_ready_o       (req_i.ready),
    .req_type_i       (req_i.req_type),
    .measured_speed_i (req_i.measured_speed),
    .mode_request_i   (req_i.mode_request),
    .s1_valid_o       (s1_valid),
    .s1_ready_i       (s1_ready),
    .s1_o             (s1)
  );

  fsp_acc u_acc (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .s1_valid_i      (s1_valid),
    .s1_ready_o      (s1_ready),
    .s1_i            (s1),
    .out_valid_o     (rsp_o.valid),
    .out_ready_i     (rsp_o.ready),
    .drive_command_o (rsp_o.drive_command),
    .target_speed_o  (rsp_o.target_speed),
    .active_mode_o   (rsp_o.active_mode)
  );

endmodule

// ===== design/fsp_cfg.sv =====
// Configuration register file.
module fsp_cfg import fsp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p        <= GAIN_P_RST;
      cfg_q.gain_i        <= GAIN_I_RST;
      cfg_q.gain_d        <= GAIN_D_RST;
      cfg_q.integral_zone <= ZONE_RST;
      cfg_q.normal_speed  <= SPEED_RST;
      cfg_q.auton_speed   <= SPEED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN_P:       cfg_q.gain_p        <= cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_I:       cfg_q.gain_i        <= cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_D:       cfg_q.gain_d        <= cfg_wdata_i[GAIN_W-1:0];
        CFG_INTEG_ZONE:   cfg_q.integral_zone <= cfg_wdata_i[ZONE_W-1:0];
        CFG_NORMAL_SPEED: cfg_q.normal_speed  <= cfg_wdata_i[SPEED_W-1:0];
        CFG_AUTON_SPEED:  cfg_q.auton_speed   <= cfg_wdata_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/fsp_err.sv =====
// Error stage: mode and target, speed error, zoned integral, error delta.
module fsp_err import fsp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     req_type_i,
  input  logic signed [MEAS_W-1:0] measured_speed_i,
  input  logic [MODE_W-1:0]        mode_request_i,
  output logic                     s1_valid_o,
  input  logic                     s1_ready_i,
  output s1_t                      s1_o
);

  logic [MODE_W-1:0]         mode_q, mode_d;
  logic [SPEED_W-1:0]        target_q, target_d;
  logic signed [ERR_W-1:0]   prev_err_q;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic                      s1_valid_q;
  s1_t                       s1_q, s1_d;

  logic signed [ERR_W-1:0]   err;
  logic [ERR_W-1:0]          err_mag;
  logic                      in_zone;
  logic signed [INTEG_W:0]   integ_sum;
  logic [SPEED_W:0]          tgt_raw;
  logic                      accept;

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    err       = ERR_W'($signed({1'b0, target_q})) - ERR_W'(measured_speed_i);
    err_mag   = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    in_zone   = (err != '0) && (err_mag < ERR_W'(cfg_i.integral_zone));
    integ_sum = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(err);

    if (!in_zone) begin
      integ_d = '0;
    end else if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      // clamp to the integral range on overflow
      integ_d = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                   : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_d = integ_sum[INTEG_W-1:0];
    end

    mode_d = (mode_q == mode_request_i) ? MODE_STOP : mode_request_i;

    case (mode_d)
      MODE_SLOW:             tgt_raw = TGT_SLOW;
      MODE_NORMAL:           tgt_raw = {1'b0, cfg_i.normal_speed};
      MODE_AUTON:            tgt_raw = {1'b0, cfg_i.auton_speed};
      MODE_AUTON_SLOW:       tgt_raw = TGT_AUTON_SLOW;
      MODE_AUTON_FIRST:      tgt_raw = {1'b0, cfg_i.normal_speed} + TGT_FIRST_ADD;
      MODE_AUTON_SLOW_FIRST: tgt_raw = {2'b00, cfg_i.auton_speed[SPEED_W-1:1]}
                                       + TGT_SLOW_ADD;
      default:               tgt_raw = '0;
    endcase
    target_d = (tgt_raw > TGT_MAX) ? TGT_MAX[SPEED_W-1:0] : tgt_raw[SPEED_W-1:0];

    s1_d.is_tick = (req_type_i == REQ_TICK);
    s1_d.err     = err;
    s1_d.derr    = DERR_W'(err) - DERR_W'(prev_err_q);
    s1_d.integ   = integ_d;
    if (req_type_i == REQ_TICK || mode_request_i == MODE_REQ_IGNORED) begin
      s1_d.target = target_q;
      s1_d.mode   = mode_q;
    end else begin
      s1_d.target = target_d;
      s1_d.mode   = mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_STOP;
      target_q   <= '0;
      prev_err_q <= '0;
      integ_q    <= '0;
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      mode_q     <= s1_d.mode;
      target_q   <= s1_d.target;
      if (req_type_i == REQ_TICK) begin
        prev_err_q <= err;
        integ_q    <= integ_d;
      end
    end else if (s1_ready_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule

// ===== design/fsp_acc.sv =====
// Accumulate stage: PID products, saturating command accumulator, result register.
module fsp_acc import fsp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    s1_valid_i,
  output logic                    s1_ready_o,
  input  s1_t                     s1_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DRV_W-1:0] drive_command_o,
  output logic [SPEED_W-1:0]      target_speed_o,
  output logic [MODE_W-1:0]       active_mode_o
);

  localparam logic signed [SUM_W-1:0] LIM_POS = SUM_W'(ACC_LIM);
  localparam logic signed [SUM_W-1:0] LIM_NEG = -LIM_POS;

  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic                       out_valid_q;
  logic signed [DRV_W-1:0]    drive_q, drive_d;
  logic [SPEED_W-1:0]         target_q;
  logic [MODE_W-1:0]          mode_q;

  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [ADJ_W-1:0]    adj;
  logic signed [SUM_W-1:0]    acc_sum;
  logic [ACC_W-1:0]           acc_mag;
  logic [ACC_W-1:0]           acc_int;
  logic                       take;

  assign s1_ready_o = !out_valid_q || out_ready_i;
  assign take       = s1_valid_i && s1_ready_o;

  always_comb begin
    prod_p  = PROD_P_W'(s1_i.err)   * PROD_P_W'($signed({1'b0, cfg_i.gain_p}));
    prod_i  = PROD_I_W'(s1_i.integ) * PROD_I_W'($signed({1'b0, cfg_i.gain_i}));
    prod_d  = PROD_D_W'(s1_i.derr)  * PROD_D_W'($signed({1'b0, cfg_i.gain_d}));
    adj     = ADJ_W'(prod_p) + ADJ_W'(prod_i) + ADJ_W'(prod_d);
    acc_sum = SUM_W'(acc_q) + SUM_W'(adj);

    if (!s1_i.is_tick) begin
      acc_d = acc_q;
    end else if (acc_sum > LIM_POS) begin
      acc_d = ACC_W'(LIM_POS);
    end else if (acc_sum < LIM_NEG) begin
      acc_d = ACC_W'(LIM_NEG);
    end else begin
      acc_d = ACC_W'(acc_sum);
    end

    // integer part, truncated toward zero
    acc_mag = acc_d[ACC_W-1] ? ACC_W'(-acc_d) : ACC_W'(acc_d);
    acc_int = acc_mag >> FRAC_BITS;
    drive_d = acc_d[ACC_W-1] ? DRV_W'(-acc_int) : DRV_W'(acc_int);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (take) begin
      acc_q       <= acc_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      drive_q  <= drive_d;
      target_q <= s1_i.target;
      mode_q   <= s1_i.mode;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_command_o = drive_q;
  assign target_speed_o  = target_q;
  assign active_mode_o   = mode_q;

endmodule
